// ===== rtl/core/sqtone_pkg.sv =====
// ----------------------------------------------------------------------------
// sqtone_pkg
// Shared types and constants of the square-tone serial audio transmitter.
// ----------------------------------------------------------------------------
package sqtone_pkg;

	// Default number of bit clocks per channel word.
	localparam int WORD_BITS_DEF = 16;

	// Widths fixed by the sample format and the register map.
	localparam int SAMPLE_W = 16;
	localparam int AMP_W    = 15;
	localparam int CHUNKS_W = 7;
	localparam int REST_W   = 10;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;

	// Dividend width of the shared divider: a rate times a millisecond rest.
	localparam int DIV_W = SAMPLE_W + REST_W;

	localparam logic [SAMPLE_W-1:0] MS_PER_S = 16'd1000;

	// Register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 1'b1;
	localparam logic [SAMPLE_W-1:0]  SAMPLE_RATE_RST = 16'd48000;
	localparam logic [AMP_W-1:0]     AMPLITUDE_RST   = 15'd16383;

	// Set-up sequencer of a play request.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PERIOD,
		ST_SECONDS,
		ST_TAIL,
		ST_LOAD
	} state_t;

endpackage

// ===== rtl/core/sqtone_div.sv =====
// ----------------------------------------------------------------------------
// sqtone_div
// Restoring divider that settles one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
module sqtone_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [sqtone_pkg::DIV_W-1:0]         dividend,
	input  logic [sqtone_pkg::SAMPLE_W-1:0]      divisor,
	output logic                                 done,
	output logic [sqtone_pkg::DIV_W-1:0]         quotient,
	output logic [sqtone_pkg::SAMPLE_W-1:0]      remainder
);

	localparam int CNT_W = $clog2(sqtone_pkg::DIV_W + 1);

	logic [sqtone_pkg::DIV_W-1:0]    quo_q;
	logic [sqtone_pkg::SAMPLE_W-1:0] rem_q;
	logic [sqtone_pkg::SAMPLE_W-1:0] dsr_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            active_q;
	logic                            done_q;

	logic [sqtone_pkg::SAMPLE_W:0]   shifted;
	logic [sqtone_pkg::SAMPLE_W:0]   diff;
	logic                            fits;

	// The partial remainder stays below the divisor, so one spare bit is enough.
	assign shifted = {rem_q, quo_q[sqtone_pkg::DIV_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign fits    = !diff[sqtone_pkg::SAMPLE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= CNT_W'(sqtone_pkg::DIV_W);
			end else if (active_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (active_q) begin
			quo_q <= {quo_q[sqtone_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? diff[sqtone_pkg::SAMPLE_W-1:0] : shifted[sqtone_pkg::SAMPLE_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/square_tone_i2s_transmitter_top.sv =====
// ----------------------------------------------------------------------------
// square_tone_i2s_transmitter_top
// Serial audio transmitter that plays a square tone for a requested time.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid, in_stall) carries two kinds of
// transaction: func = 1 is a play request with duration_ms and tone_freq, and
// func = 0 is one bit clock tick. While a tone plays, every tick gives one
// output transaction (lr_select, serial_bit, last): the left word and then the
// same word again as the right word, MSB first, WORD_BITS bits each. The
// flag last marks the final bit of the playback. Ticks while idle give
// nothing, and a play request during playback is dropped.
// Flow. A tick's result is registered and offered in the following cycle;
// one tick is accepted per cycle while in_stall is low. During a play request
// the bit-serial divider runs three times (period, seconds, tail samples),
// then the first sample is loaded.
// In that time in_stall is held high.
// Reset puts the block idle with sample_rate 48000 and amplitude 16383.
// When the receiver stalls, the result waits in the output register and
// in_stall rises, so no tick is taken until the output slot frees.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// belong in idle periods.
// ----------------------------------------------------------------------------
module square_tone_i2s_transmitter_top #(
	parameter int WORD_BITS = sqtone_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic [15:0]                         duration_ms,
	input  logic [15:0]                         tone_freq,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                lr_select,
	output logic                                serial_bit,
	output logic                                last,
	input  logic                                cfg_we,
	input  logic [sqtone_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sqtone_pkg::CFG_W-1:0]        cfg_data
);

	localparam int SW = sqtone_pkg::SAMPLE_W;
	localparam int BP_W = $clog2(WORD_BITS);

	// Configuration registers.
	logic [SW-1:0]                  rate_q;
	logic [sqtone_pkg::AMP_W-1:0]   amp_q;

	// Sequencer and playback control.
	sqtone_pkg::state_t             state_q, state_d;
	logic                           busy_q;
	logic                           chan_q;
	logic [BP_W-1:0]                bitpos_q;
	logic                           out_valid_q;

	// Playback payload.
	logic [SW-1:0]                  ms_q;
	logic [SW-1:0]                  period_q;
	logic [sqtone_pkg::AMP_W-1:0]   high_q;
	logic [SW-1:0]                  phase_q;
	logic [SW-1:0]                  chunk_q;
	logic [sqtone_pkg::CHUNKS_W-1:0] whole_q;
	logic [SW-1:0]                  tail_q;
	logic [SW-1:0]                  word_q;
	logic [SW-1:0]                  shift_q;
	logic                           lr_q, bit_q, last_q;

	// Handshake decode.
	logic in_take, play_go, tick_go;

	// Divider hookup.
	logic                            div_start, div_done;
	logic [sqtone_pkg::DIV_W-1:0]    div_dividend, div_quo;
	logic [SW-1:0]                   div_divisor, div_rem;
	logic [SW-1:0]                   freq_clamped, period_new;

	// Sequencer actions.
	logic cap_period, cap_secs, cap_tail, do_load;

	// Per-tick helpers.
	logic                            last_bit;
	logic [SW-1:0]                   chunk_dec;
	logic [SW:0]                     phase_inc;
	logic [SW-1:0]                   phase_wrap;
	logic [SW-1:0]                   word_pos, word_neg, word_zero, word_wrap;
	logic                            chunk_end, end_play;

	// Next-chunk selection.
	logic                            nc_ok;
	logic [SW-1:0]                   nc_chunk;
	logic [sqtone_pkg::CHUNKS_W-1:0] nc_whole;
	logic [SW-1:0]                   nc_tail;

	assign in_stall = (state_q != sqtone_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign in_take  = in_valid && !in_stall;
	assign play_go  = in_take && func && !busy_q;
	assign tick_go  = in_take && !func && busy_q;

	// A configuration write lands at once; an unknown index cannot be encoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= sqtone_pkg::SAMPLE_RATE_RST;
			amp_q  <= sqtone_pkg::AMPLITUDE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sqtone_pkg::REG_SAMPLE_RATE: rate_q <= cfg_data[SW-1:0];
				sqtone_pkg::REG_AMPLITUDE:   amp_q  <= cfg_data[sqtone_pkg::AMP_W-1:0];
				default: ;
			endcase
		end
	end

	// A zero frequency plays as one hertz.
	assign freq_clamped = (tone_freq == '0) ? SW'(1) : tone_freq;
	// A period of zero samples is clamped to one.
	assign period_new = (div_quo[SW-1:0] == '0) ? SW'(1) : div_quo[SW-1:0];

	sqtone_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sqtone_pkg::ST_IDLE:    if (play_go)  state_d = sqtone_pkg::ST_PERIOD;
			sqtone_pkg::ST_PERIOD:  if (div_done) state_d = sqtone_pkg::ST_SECONDS;
			sqtone_pkg::ST_SECONDS: if (div_done) state_d = sqtone_pkg::ST_TAIL;
			sqtone_pkg::ST_TAIL:    if (div_done) state_d = sqtone_pkg::ST_LOAD;
			sqtone_pkg::ST_LOAD:    state_d = sqtone_pkg::ST_IDLE;
			default:                state_d = sqtone_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs. Each division is launched as the previous one
	// finishes; the tail product feeds the divider's input register directly.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = sqtone_pkg::DIV_W'(rate_q);
		div_divisor  = sqtone_pkg::MS_PER_S;
		cap_period   = 1'b0;
		cap_secs     = 1'b0;
		cap_tail     = 1'b0;
		do_load      = 1'b0;
		unique case (state_q)
			sqtone_pkg::ST_IDLE: begin
				div_start   = play_go;
				div_divisor = freq_clamped;
			end
			sqtone_pkg::ST_PERIOD: begin
				cap_period   = div_done;
				div_start    = div_done;
				div_dividend = sqtone_pkg::DIV_W'(ms_q);
			end
			sqtone_pkg::ST_SECONDS: begin
				cap_secs     = div_done;
				div_start    = div_done;
				div_dividend = rate_q * div_rem[sqtone_pkg::REST_W-1:0];
			end
			sqtone_pkg::ST_TAIL: begin
				cap_tail = div_done;
			end
			sqtone_pkg::ST_LOAD: begin
				do_load = 1'b1;
			end
			default: ;
		endcase
	end

	// Whole chunks go first; a whole chunk with a zero rate drops all of them.
	always_comb begin
		if (whole_q != '0 && rate_q != '0) begin
			nc_ok    = 1'b1;
			nc_chunk = rate_q;
			nc_whole = whole_q - 1'b1;
			nc_tail  = tail_q;
		end else if (tail_q != '0) begin
			nc_ok    = 1'b1;
			nc_chunk = tail_q;
			nc_whole = '0;
			nc_tail  = '0;
		end else begin
			nc_ok    = 1'b0;
			nc_chunk = '0;
			nc_whole = '0;
			nc_tail  = tail_q;
		end
	end

	assign last_bit   = (bitpos_q == BP_W'(WORD_BITS - 1));
	assign chunk_dec  = (chunk_q != '0) ? chunk_q - 1'b1 : chunk_q;
	assign phase_inc  = {1'b0, phase_q} + 1'b1;
	assign phase_wrap = (phase_inc >= {1'b0, period_q}) ? '0 : phase_inc[SW-1:0];
	assign word_pos   = SW'(amp_q);
	assign word_neg   = SW'(0) - SW'(amp_q);
	// The high half of each wave covers phases below the half period.
	assign word_zero  = (high_q != '0) ? word_pos : word_neg;
	assign word_wrap  = (phase_wrap < SW'(high_q)) ? word_pos : word_neg;
	assign chunk_end  = (chunk_dec == '0);
	assign end_play   = last_bit && chan_q && chunk_end && !nc_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sqtone_pkg::ST_IDLE;
			busy_q      <= 1'b0;
			chan_q      <= 1'b0;
			bitpos_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_load) begin
				busy_q   <= nc_ok;
				chan_q   <= 1'b0;
				bitpos_q <= '0;
			end else if (tick_go) begin
				if (end_play) busy_q <= 1'b0;
				if (last_bit) begin
					bitpos_q <= '0;
					chan_q   <= !chan_q;
				end else begin
					bitpos_q <= bitpos_q + 1'b1;
				end
			end
			if (tick_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (play_go) ms_q <= duration_ms;
		if (cap_period) begin
			period_q <= period_new;
			high_q   <= period_new[SW-1:1];
		end
		if (cap_secs) whole_q <= div_quo[sqtone_pkg::CHUNKS_W-1:0];
		if (cap_tail) tail_q  <= div_quo[SW-1:0];
		if (do_load) begin
			chunk_q <= nc_chunk;
			whole_q <= nc_whole;
			tail_q  <= nc_tail;
			phase_q <= '0;
			word_q  <= word_zero;
			shift_q <= word_zero;
		end else if (tick_go) begin
			lr_q   <= chan_q;
			bit_q  <= shift_q[SW-1];
			last_q <= end_play;
			if (!last_bit) begin
				// Zeros shift in, which pads words longer than a sample.
				shift_q <= {shift_q[SW-2:0], 1'b0};
			end else if (!chan_q) begin
				shift_q <= word_q;
			end else if (chunk_end) begin
				chunk_q <= nc_chunk;
				whole_q <= nc_whole;
				tail_q  <= nc_tail;
				phase_q <= '0;
				word_q  <= word_zero;
				shift_q <= word_zero;
			end else begin
				chunk_q <= chunk_dec;
				phase_q <= phase_wrap;
				word_q  <= word_wrap;
				shift_q <= word_wrap;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign lr_select  = lr_q;
	assign serial_bit = bit_q;
	assign last       = last_q;

endmodule

// ===== rtl/core/sqtone_chk.sv =====
// ----------------------------------------------------------------------------
// sqtone_chk
// Port-level checks of the square-tone transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module sqtone_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             lr_select,
	input logic                             serial_bit,
	input logic                             last
);

	// A stalled result transaction stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result transaction keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({lr_select, serial_bit, last}))
		else $error("result payload changed while stalled");

	// The block never takes a tick while its single output slot is blocked.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while the output slot is blocked");

	// Nothing follows the final bit of a playback without a new request.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid)
		else $error("result seen straight after the final bit");

endmodule

bind square_tone_i2s_transmitter_top sqtone_chk u_sqtone_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.lr_select  (lr_select),
	.serial_bit (serial_bit),
	.last       (last)
);
